[hw/rtl/salc_pkg.sv]
// Shared types and constants for the set-associative LRU cache model.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

    localparam int MAX_SETS  = 256;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int MAX_WAYS  = 8;
    localparam int WAY_W     = 3;
    localparam int WAY_CNT_W = 4;
    localparam int TAG_W     = 32;
    localparam int RANK_W    = 3;
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CMD_W     = 2;
    localparam int SIW_W     = 4;
    localparam int OFW_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int OUT_W     = 104;

    localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STORE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_SCAN,
        ST_UPD
    } state_t;

    // One set: valid bits, tags and LRU ranks of all ways.
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } row_t;

    // Findings of a scan over the ways of one set.
    typedef struct packed {
        logic             last;
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             free;
        logic [WAY_W-1:0] free_way;
        logic             zero;
        logic [WAY_W-1:0] zero_way;
    } scan_t;

endpackage
`default_nettype wire

[hw/rtl/salc_set_store.sv]
// Set storage: one row per set, with per-row valid flops cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
module salc_set_store (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      rd_en,
    input  wire logic [salc_pkg::SET_W-1:0] rd_set,
    output salc_pkg::row_t                 rd_row,
    input  wire logic                      wr_en,
    input  wire logic [salc_pkg::SET_W-1:0] wr_set,
    input  wire salc_pkg::row_t            wr_row
);

    salc_pkg::row_t                    mem [salc_pkg::MAX_SETS];
    salc_pkg::row_t                    data_reg;
    logic                              ok_reg;
    logic [salc_pkg::MAX_SETS-1:0]     row_ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_set] <= wr_row;
        end
        if (rd_en) begin
            data_reg <= mem[rd_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
            ok_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                row_ok_reg[wr_set] <= 1'b1;
            end
            if (rd_en) begin
                ok_reg <= row_ok_reg[rd_set];
            end
        end
    end

    // A never-written set reads as empty with all ranks zero.
    assign rd_row = ok_reg ? data_reg : '0;

endmodule
`default_nettype wire

[hw/rtl/salc_way_scan.sv]
// Shared tag/rank compare unit, stepped over the ways of a set one per cycle.
`timescale 1ns / 1ps
`default_nettype none
module salc_way_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic                          step,
    input  wire salc_pkg::row_t                row,
    input  wire logic [salc_pkg::TAG_W-1:0]     tag,
    input  wire logic [salc_pkg::WAY_CNT_W-1:0] ways_cnt,
    output salc_pkg::scan_t                    scan
);

    logic [salc_pkg::WAY_W-1:0] way_reg;
    logic                       hit_reg;
    logic [salc_pkg::WAY_W-1:0] hit_way_reg;
    logic                       free_reg;
    logic [salc_pkg::WAY_W-1:0] free_way_reg;
    logic                       zero_reg;
    logic [salc_pkg::WAY_W-1:0] zero_way_reg;
    logic                       is_last;
    logic                       match;
    logic                       empty;
    logic                       rank0;

    assign is_last = ({1'b0, way_reg} == (ways_cnt - salc_pkg::WAY_CNT_W'(1)));
    assign match   = row.valid[way_reg] && (row.tag[way_reg] == tag);
    assign empty   = !row.valid[way_reg];
    assign rank0   = (row.rank[way_reg] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            zero_reg <= 1'b0;
        end else if (start) begin
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            zero_reg <= 1'b0;
        end else if (step) begin
            // keep only the first way that qualifies
            if (match && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= way_reg;
            end
            if (empty && !free_reg) begin
                free_reg     <= 1'b1;
                free_way_reg <= way_reg;
            end
            if (rank0 && !zero_reg) begin
                zero_reg     <= 1'b1;
                zero_way_reg <= way_reg;
            end
            if (!is_last) begin
                way_reg <= way_reg + salc_pkg::WAY_W'(1);
            end
        end
    end

    always_comb begin
        scan.last     = is_last;
        scan.hit      = hit_reg;
        scan.hit_way  = hit_way_reg;
        scan.free     = free_reg;
        scan.free_way = free_way_reg;
        scan.zero     = zero_reg;
        scan.zero_way = zero_way_reg;
    end

endmodule
`default_nettype wire

[hw/rtl/set_assoc_lru_cache_sim.sv]
// Top level of the tag-only set-associative cache model with LRU replacement.
// Input channel s_*: one memory access per transfer, command in s_tuser and
// byte address in s_tdata. A fetch is taken and dropped; a load or store gives
// one result, a modify gives two results to the same address, the second
// with m_tlast high (a single result also has m_tlast high).
// Each access first splits the address and reads the set row, then scans
// each active way in turn through the shared compare unit, then picks the
// way, writes the ranks and tag back and loads the result register.
// The result register frees the engine while a result waits; if the receiver
// holds m_tready low, the next access waits in its write-back cycle.
// s_tready is high only while no access is in progress.
// Reset (aresetn low, synchronous) empties every set at once, zeroes the
// ranks and the hit, miss and eviction counters and restores the defaults
// of four set bits, four offset bits and four ways. No clearing pass is run.
// Write configuration (cfg_we) only while the block is idle and no result waits.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_sim (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [salc_pkg::CFG_DAT_W-1:0] cfg_wdata,
    // access input
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [salc_pkg::ADDR_W-1:0]    s_tdata,  // address[31:0]
    input  wire logic [salc_pkg::CMD_W-1:0]     s_tuser,  // command[1:0]
    // result output
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hit[0], evicted[1], way_used[4:2], hits_total[36:5],
    // misses_total[68:37], evictions_total[100:69], zero pad[103:101]
    output logic [salc_pkg::OUT_W-1:0]          m_tdata,
    output logic                               m_tlast
);

    localparam int SH_W = salc_pkg::OFW_W + 1;

    salc_pkg::state_t state_reg, state_next;

    logic [salc_pkg::SIW_W-1:0]     siw_reg;
    logic [salc_pkg::OFW_W-1:0]     ofw_reg;
    logic [salc_pkg::WAY_CNT_W-1:0] ways_reg;

    logic [salc_pkg::CMD_W-1:0]  cmd_reg;
    logic [salc_pkg::ADDR_W-1:0] addr_reg;
    logic                        second_reg, second_next;
    logic [salc_pkg::TAG_W-1:0]  tag_reg;
    logic [salc_pkg::SET_W-1:0]  set_reg;

    logic [salc_pkg::CNT_W-1:0] hits_reg, misses_reg, evicts_reg;
    logic [salc_pkg::CNT_W-1:0] hits_next, misses_next, evicts_next;

    logic                       m_valid_reg;
    logic [salc_pkg::OUT_W-1:0] m_data_reg;
    logic                       m_last_reg;

    logic                        in_fire;
    logic                        rd_en;
    logic                        scan_start;
    logic                        scan_step;
    logic                        upd_fire;
    logic                        out_free;
    logic [salc_pkg::WAY_CNT_W-1:0] ways_eff;
    logic [SH_W-1:0]             tag_sh;
    logic [salc_pkg::ADDR_W-1:0] ofs_shifted;
    logic [salc_pkg::TAG_W-1:0]  tag_calc;
    logic [salc_pkg::SET_W-1:0]  set_mask;
    logic [salc_pkg::SET_W-1:0]  set_calc;

    salc_pkg::row_t  row;
    salc_pkg::row_t  new_row;
    salc_pkg::scan_t scan;

    logic                        acc_hit;
    logic                        acc_evict;
    logic [salc_pkg::WAY_W-1:0]  acc_way;
    logic [salc_pkg::RANK_W-1:0] way_rank;
    logic                        acc_last;

    // ---------------------------------------------------------------------
    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            siw_reg  <= salc_pkg::SIW_W'(4);
            ofw_reg  <= salc_pkg::OFW_W'(4);
            ways_reg <= salc_pkg::WAY_CNT_W'(4);
        end else if (cfg_we) begin
            case (cfg_index)
                salc_pkg::CFG_SET_BITS: siw_reg  <= cfg_wdata[salc_pkg::SIW_W-1:0];
                salc_pkg::CFG_OFS_BITS: ofw_reg  <= cfg_wdata;
                salc_pkg::CFG_WAYS:     ways_reg <= cfg_wdata[salc_pkg::WAY_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp associativity to 1..MAX_WAYS
    always_comb begin
        if (ways_reg == '0) begin
            ways_eff = salc_pkg::WAY_CNT_W'(1);
        end else if (ways_reg > salc_pkg::WAY_CNT_W'(salc_pkg::MAX_WAYS)) begin
            ways_eff = salc_pkg::WAY_CNT_W'(salc_pkg::MAX_WAYS);
        end else begin
            ways_eff = ways_reg;
        end
    end

    // ---------------------------------------------------------------------
    // address split
    assign tag_sh      = SH_W'(siw_reg) + SH_W'(ofw_reg);
    assign ofs_shifted = addr_reg >> ofw_reg;
    assign tag_calc    = tag_sh[SH_W-1] ? '0 : (addr_reg >> tag_sh[SH_W-2:0]);

    always_comb begin
        for (int i = 0; i < salc_pkg::SET_W; i++) begin
            set_mask[i] = (salc_pkg::SIW_W'(i) < siw_reg);
        end
    end

    assign set_calc = ofs_shifted[salc_pkg::SET_W-1:0] & set_mask;

    // ---------------------------------------------------------------------
    // set storage and compare unit
    salc_set_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_set  (set_calc),
        .rd_row  (row),
        .wr_en   (upd_fire),
        .wr_set  (set_reg),
        .wr_row  (new_row)
    );

    salc_way_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .step     (scan_step),
        .row      (row),
        .tag      (tag_reg),
        .ways_cnt (ways_eff),
        .scan     (scan)
    );

    // ---------------------------------------------------------------------
    // way choice and rank update
    always_comb begin
        acc_hit   = scan.hit;
        acc_evict = !scan.hit && !scan.free;
        if (scan.hit) begin
            acc_way = scan.hit_way;
        end else if (scan.free) begin
            acc_way = scan.free_way;
        end else if (scan.zero) begin
            acc_way = scan.zero_way;
        end else begin
            acc_way = '0;
        end
        way_rank = row.rank[acc_way];

        new_row = row;
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
            if ((salc_pkg::WAY_CNT_W'(i) < ways_eff) && row.valid[i]
                    && (row.rank[i] > way_rank)) begin
                new_row.rank[i] = row.rank[i] - salc_pkg::RANK_W'(1);
            end
        end
        new_row.valid[acc_way] = 1'b1;
        new_row.tag[acc_way]   = tag_reg;
        new_row.rank[acc_way]  = salc_pkg::RANK_W'(ways_eff - salc_pkg::WAY_CNT_W'(1));
    end

    // saturating counters
    always_comb begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        if (acc_hit) begin
            if (hits_reg != salc_pkg::CNT_MAX) begin
                hits_next = hits_reg + salc_pkg::CNT_W'(1);
            end
        end else begin
            if (misses_reg != salc_pkg::CNT_MAX) begin
                misses_next = misses_reg + salc_pkg::CNT_W'(1);
            end
        end
        if (acc_evict && (evicts_reg != salc_pkg::CNT_MAX)) begin
            evicts_next = evicts_reg + salc_pkg::CNT_W'(1);
        end
    end

    assign acc_last = (cmd_reg != salc_pkg::CMD_MODIFY) || second_reg;

    // ---------------------------------------------------------------------
    // sequencer
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            salc_pkg::ST_IDLE: begin
                if (s_tvalid && (s_tuser != salc_pkg::CMD_FETCH)) begin
                    state_next  = salc_pkg::ST_ADDR;
                    second_next = 1'b0;
                end
            end
            salc_pkg::ST_ADDR: begin
                state_next = salc_pkg::ST_SCAN;
            end
            salc_pkg::ST_SCAN: begin
                if (scan.last) begin
                    state_next = salc_pkg::ST_UPD;
                end
            end
            salc_pkg::ST_UPD: begin
                if (out_free) begin
                    if (acc_last) begin
                        state_next = salc_pkg::ST_IDLE;
                    end else begin
                        state_next  = salc_pkg::ST_ADDR;
                        second_next = 1'b1;
                    end
                end
            end
            default: state_next = salc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        scan_start = 1'b0;
        scan_step  = 1'b0;
        upd_fire   = 1'b0;
        case (state_reg)
            salc_pkg::ST_IDLE: s_tready = 1'b1;
            salc_pkg::ST_ADDR: begin
                rd_en      = 1'b1;
                scan_start = 1'b1;
            end
            salc_pkg::ST_SCAN: scan_step = 1'b1;
            salc_pkg::ST_UPD:  upd_fire  = out_free;
            default: ;
        endcase
    end

    assign in_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= salc_pkg::ST_IDLE;
            second_reg  <= 1'b0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            evicts_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
            if (upd_fire) begin
                hits_reg    <= hits_next;
                misses_reg  <= misses_next;
                evicts_reg  <= evicts_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata;
        end
        if (rd_en) begin
            tag_reg <= tag_calc;
            set_reg <= set_calc;
        end
        if (upd_fire) begin
            m_data_reg <= {3'b000, evicts_next, misses_next, hits_next,
                           acc_way, acc_evict, acc_hit};
            m_last_reg <= acc_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

[tb/sv/set_assoc_lru_cache_sim_tb.sv]
// Self-checking bench for the LRU cache model, scored against a shadow cache.
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_tb;
    import salc_pkg::*;

    localparam int LIMIT  = 1_000_000;
    localparam int SETTLE = 32;
    localparam int PER_SETTING = 125;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
        logic             closing;
    } access_result_t;

    // Shadow copy of the cache: tags, valid bits, ranks, counters and settings.
    class lru_shadow;
        logic [SIW_W-1:0]     set_bits;
        logic [OFW_W-1:0]     ofs_bits;
        logic [WAY_CNT_W-1:0] ways_cfg;
        bit                   line_ok   [MAX_SETS*MAX_WAYS];
        logic [TAG_W-1:0]     line_tag  [MAX_SETS*MAX_WAYS];
        logic [RANK_W-1:0]    line_rank [MAX_SETS*MAX_WAYS];
        logic [CNT_W-1:0]     hit_cnt, miss_cnt, evict_cnt;
        access_result_t       pending [$];
        int errors, accesses, checked, hits_seen, evicts_seen;

        function new();
            set_bits = SIW_W'(4);
            ofs_bits = OFW_W'(4);
            ways_cfg = WAY_CNT_W'(4);
            foreach (line_ok[i]) begin
                line_ok[i]   = 1'b0;
                line_rank[i] = '0;
            end
            hit_cnt = '0;
            miss_cnt = '0;
            evict_cnt = '0;
            errors = 0;
            accesses = 0;
            checked = 0;
            hits_seen = 0;
            evicts_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_SET_BITS: set_bits = val[SIW_W-1:0];
                CFG_OFS_BITS: ofs_bits = val[OFW_W-1:0];
                CFG_WAYS:     ways_cfg = val[WAY_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_access(logic [ADDR_W-1:0] addr, logic closing);
            logic [63:0]       wide, shifted, set_mask, slot;
            logic [RANK_W-1:0] r;
            int                s, b, e, base, way, i;
            bit                hit, ev, found;
            access_result_t    res;
            s = int'(set_bits);
            b = int'(ofs_bits);
            e = int'(ways_cfg);
            if (e == 0) e = 1;
            if (e > MAX_WAYS) e = MAX_WAYS;
            wide     = {32'd0, addr};
            shifted  = wide >> (s + b);
            set_mask = (64'd1 << s) - 64'd1;
            // set indexes beyond the storage wrap around
            slot     = ((wide >> b) & set_mask) % MAX_SETS;
            base     = int'(slot) * MAX_WAYS;
            hit = 1'b0;
            ev = 1'b0;
            found = 1'b0;
            way = 0;
            for (i = 0; i < e; i++) begin
                if (!hit && line_ok[base+i] && line_tag[base+i] == shifted[TAG_W-1:0]) begin
                    way = i;
                    hit = 1'b1;
                end
            end
            if (hit) begin
                if (hit_cnt != CNT_MAX) hit_cnt++;
            end else begin
                if (miss_cnt != CNT_MAX) miss_cnt++;
                for (i = 0; i < e; i++) begin
                    if (!found && !line_ok[base+i]) begin
                        way = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    ev = 1'b1;
                    if (evict_cnt != CNT_MAX) evict_cnt++;
                    // with no rank-0 way in range, way 0 is replaced
                    for (i = 0; i < e; i++) begin
                        if (!found && line_rank[base+i] == '0) begin
                            way = i;
                            found = 1'b1;
                        end
                    end
                end
                line_ok[base+way]  = 1'b1;
                line_tag[base+way] = shifted[TAG_W-1:0];
            end
            r = line_rank[base+way];
            for (i = 0; i < e; i++) begin
                if (line_ok[base+i] && line_rank[base+i] > r)
                    line_rank[base+i] = line_rank[base+i] - 1'b1;
            end
            line_rank[base+way] = RANK_W'(e - 1);
            res.hit       = hit;
            res.evicted   = ev;
            res.way       = WAY_W'(way);
            res.hits      = hit_cnt;
            res.misses    = miss_cnt;
            res.evictions = evict_cnt;
            res.closing   = closing;
            pending.push_back(res);
        endfunction

        function void note_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
            if (cmd == CMD_FETCH) return;
            accesses++;
            if (cmd == CMD_MODIFY) predict_access(addr, 1'b0);
            predict_access(addr, 1'b1);
        endfunction

        function void compare(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic last_bit);
            access_result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result, expected none, actual %0h last %0b",
                             $time, data, last_bit);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.hit) hits_seen++;
            if (want.evicted) evicts_seen++;
            compare("hit", CNT_W'(want.hit), CNT_W'(data[0]));
            compare("evicted", CNT_W'(want.evicted), CNT_W'(data[1]));
            compare("way_used", CNT_W'(want.way), CNT_W'(data[4:2]));
            compare("hits_total", want.hits, data[36:5]);
            compare("misses_total", want.misses, data[68:37]);
            compare("evictions_total", want.evictions, data[100:69]);
            compare("pad", '0, CNT_W'(data[OUT_W-1:101]));
            compare("last", CNT_W'(want.closing), CNT_W'(last_bit));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [ADDR_W-1:0]    s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = CMD_FETCH;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;

    int        cycles = 0;
    int        stall_mode = 0;
    int        stall_left = 0;
    int        settings_run = 0;
    lru_shadow shadow;

    set_assoc_lru_cache_sim u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Run stopped at the cycle limit, %0d results outstanding",
                     shadow.pending.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: switch between always ready, light, heavy and near-total stalls.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 1) == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shadow.check_result(m_tdata, m_tlast);
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        shadow.note_access(cmd, addr);
    endtask

    task automatic hold_off(int n);
        @(negedge aclk) s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (shadow.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        shadow.write_reg(idx, val);
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // Mostly a few tags over a few sets so lines get hit and evicted.
    function automatic logic [ADDR_W-1:0] pick_address(int s, int b, int e,
                                                       logic [ADDR_W-1:0] tag_base);
        logic [63:0] tag, set_no, ofs, a;
        int          sel;
        sel    = $urandom_range(0, 9);
        tag    = {32'd0, tag_base + ADDR_W'($urandom_range(0, e + 2))};
        set_no = (sel < 8) ? 64'($urandom_range(0, 3)) : {$urandom(), $urandom()};
        ofs    = {$urandom(), $urandom()};
        a = (tag << (s + b)) | ((set_no & ((64'd1 << s) - 64'd1)) << b)
            | (ofs & ((64'd1 << b) - 64'd1));
        if (sel < 2) a = {32'd0, $urandom()};
        return a[ADDR_W-1:0];
    endfunction

    task automatic run_setting(int s, int b, int w, int n);
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] tag_base;
        int                done, burst, e;
        bit                paused;
        settle();
        write_reg(CFG_SET_BITS, CFG_DAT_W'(s));
        write_reg(CFG_OFS_BITS, CFG_DAT_W'(b));
        write_reg(CFG_WAYS, CFG_DAT_W'(w));
        settings_run++;
        e = (w == 0) ? 1 : ((w > MAX_WAYS) ? MAX_WAYS : w);
        tag_base = ($urandom_range(0, 3) == 0) ? '0 : ADDR_W'($urandom());
        done = 0;
        paused = 1'b0;
        while (done < n) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && done < n) begin
                cmd = CMD_W'($urandom_range(0, 3));
                send_item(cmd, pick_address(s, b, e, tag_base));
                done++;
                burst--;
            end
            if (!paused && done >= n / 2) begin
                settle();
                paused = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                hold_off($urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        shadow = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Reset settings: 4 set bits, 4 offset bits, 4 ways; set 0 is filled then evicted.
        send_item(CMD_FETCH, 32'h0000_0000);
        send_item(CMD_LOAD, 32'h0000_0000);
        send_item(CMD_STORE, 32'h0000_0000);
        send_item(CMD_MODIFY, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 32'h0000_0100);
        send_item(CMD_LOAD, 32'h0000_0200);
        send_item(CMD_LOAD, 32'h0000_0300);
        send_item(CMD_LOAD, 32'h0000_0400);
        send_item(CMD_STORE, 32'h0000_010C);
        send_item(CMD_FETCH, 32'hFFFF_FFFF);
        send_item(CMD_MODIFY, 32'h8000_0070);
        send_item(CMD_STORE, 32'h7FFF_FFF0);
        settle();

        // Shrink to two ways: set 0 keeps ranks 2 and 3 there, so way 0 goes.
        write_reg(CFG_WAYS, CFG_DAT_W'(2));
        send_item(CMD_LOAD, 32'h0000_0500);
        send_item(CMD_LOAD, 32'h0000_0500);
        send_item(CMD_MODIFY, 32'h0000_0600);
        send_item(CMD_FETCH, 32'h5555_AAAA);

        run_setting(4, 4, 4, PER_SETTING);
        run_setting(1, 1, 1, PER_SETTING);
        run_setting(8, 23, 8, PER_SETTING);
        run_setting(0, 0, 0, PER_SETTING);
        run_setting(15, 31, 15, PER_SETTING);
        run_setting(2, 5, 8, PER_SETTING);
        run_setting(8, 4, 2, PER_SETTING);
        run_setting(3, 6, 5, PER_SETTING);
        run_setting(12, 20, 3, PER_SETTING);
        run_setting($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15),
                    PER_SETTING);
        run_setting($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15),
                    PER_SETTING);
        settle();

        $display("Checked %0d results (%0d hits, %0d evictions) from %0d data accesses",
                 shadow.checked, shadow.hits_seen, shadow.evicts_seen, shadow.accesses);
        $display("Ran %0d cache settings, among them zero and over-range ways and set bits",
                 settings_run);
        if (shadow.errors == 0 && shadow.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
